/* rtl/core/ntb_pkg.sv */
// ============================================================================
// ntb_pkg: shared types and constants of the N-Triples term boundary scanner
// Character codes, result records, the per-byte result bundle and the
// sizing of the queue between the front and the back part.
// ============================================================================
package ntb_pkg;

    // Longest line that keeps distinct positions. Bytes past it report
    // LINE_MAX-1 and raise the too-long flag.
    localparam int LINE_MAX = 4096;
    // The byte counter must hold LINE_MAX itself.
    localparam int POS_W    = $clog2(LINE_MAX + 1);
    localparam int OUT_POS_W = 12;
    localparam int IDX_W     = 6;
    localparam logic [IDX_W-1:0] IDX_MAX = '1;

    // Bundles of results that the queue can hold.
    localparam int Q_DEPTH = 4;
    localparam int Q_PTR_W = $clog2(Q_DEPTH);

    localparam logic [7:0] CH_LT     = 8'h3C;  // '<'
    localparam logic [7:0] CH_GT     = 8'h3E;  // '>'
    localparam logic [7:0] CH_QUOTE  = 8'h22;  // '"'
    localparam logic [7:0] CH_UNDER  = 8'h5F;  // '_'
    localparam logic [7:0] CH_SPACE  = 8'h20;  // ' '
    localparam logic [7:0] CH_BSLASH = 8'h5C;  // '\'

    typedef enum logic [1:0] {
        KIND_START       = 2'd0,
        KIND_CONTENT_END = 2'd1,
        KIND_QUAL_END    = 2'd2,
        KIND_LINE_END    = 2'd3
    } t_kind;

    typedef struct packed {
        logic                   too_long;
        logic [IDX_W-1:0]       idx;
        t_kind                  kind;
        logic [OUT_POS_W-1:0]   pos;
    } t_rec;

    // Everything that one byte produces: up to three records, in order.
    typedef struct packed {
        logic [1:0]      cnt;
        t_rec [2:0]      recs;
    } t_bundle;

    typedef struct packed {
        logic empty;
        logic full;
    } t_q_status;

    // Saturating add of a small amount to the marker counter.
    function automatic logic [IDX_W-1:0] sat_add(input logic [IDX_W-1:0] a,
                                                 input logic [1:0] b);
        logic [IDX_W:0] sum;
        sum = {1'b0, a} + {{(IDX_W-1){1'b0}}, b};
        if (sum > {1'b0, IDX_MAX}) begin
            return IDX_MAX;
        end
        return sum[IDX_W-1:0];
    endfunction

    // Fit a byte position into the 12-bit position field.
    function automatic logic [OUT_POS_W-1:0] to_out_pos(input logic [POS_W-1:0] p);
        logic [POS_W+OUT_POS_W-1:0] wide;
        wide = {{OUT_POS_W{1'b0}}, p};
        return wide[OUT_POS_W-1:0];
    endfunction

endpackage

/* rtl/core/ntb_front.sv */
// ============================================================================
// ntb_front: byte classifier and scan state
// Tracks the open term, the pending '>' and the backslash parity, and turns
// each accepted byte into a bundle of zero to three boundary records.
// ============================================================================
module ntb_front
    import ntb_pkg::*;
(
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_accept,
    input  logic [7:0]  i_ch,
    input  logic        i_line_last,
    output t_bundle     o_bundle
);

    typedef enum logic [2:0] {
        MODE_IDLE  = 3'd0,
        MODE_IRI   = 3'd1,
        MODE_BLANK = 3'd2,
        MODE_LIT   = 3'd3,
        MODE_QUAL  = 3'd4
    } t_mode;

    localparam logic [POS_W-1:0] LIMIT     = POS_W'(LINE_MAX);
    localparam logic [POS_W-1:0] LIMIT_M1  = POS_W'(LINE_MAX - 1);

    t_mode              r_mode, n_mode;
    logic               r_angle, n_angle;
    logic               r_parity, n_parity;
    logic [POS_W-1:0]   r_pos, n_pos;
    logic [IDX_W-1:0]   r_count, n_count;
    logic               r_ovf, n_ovf;

    logic               sat;
    logic               ovf;
    logic [POS_W-1:0]   cur, prev, mk_pos;
    logic [1:0]         mk_n;
    t_kind              kind_a, kind_b;
    t_rec               rec_a, rec_b, rec_end;

    always_comb begin
        sat    = (r_pos >= LIMIT);
        ovf    = r_ovf | sat;
        cur    = sat ? LIMIT_M1 : r_pos;
        // Past the limit the previous offset sticks at the same saturated value.
        prev   = sat ? LIMIT_M1 : ((r_pos == '0) ? '0 : r_pos - POS_W'(1));

        n_mode   = r_mode;
        n_angle  = r_angle;
        n_parity = r_parity;
        mk_n     = 2'd0;
        mk_pos   = cur;
        kind_a   = KIND_START;
        kind_b   = KIND_QUAL_END;

        case (r_mode)
            MODE_IDLE: begin
                if (i_ch == CH_LT) begin
                    mk_n    = 2'd1;
                    n_mode  = MODE_IRI;
                    n_angle = 1'b0;
                end else if (i_ch == CH_QUOTE) begin
                    mk_n     = 2'd1;
                    n_mode   = MODE_LIT;
                    n_parity = 1'b0;
                end else if (i_ch == CH_UNDER) begin
                    mk_n   = 2'd1;
                    n_mode = MODE_BLANK;
                end
            end
            MODE_IRI: begin
                // A '>' only closes the IRI when a space follows it.
                if (r_angle && i_ch == CH_SPACE) begin
                    n_angle = 1'b0;
                    mk_n    = 2'd2;
                    mk_pos  = prev;
                    kind_a  = KIND_CONTENT_END;
                    n_mode  = MODE_IDLE;
                end else begin
                    n_angle = (i_ch == CH_GT) && !i_line_last;
                end
            end
            MODE_BLANK: begin
                if (i_ch == CH_SPACE) begin
                    mk_n   = 2'd2;
                    mk_pos = prev;
                    kind_a = KIND_CONTENT_END;
                    n_mode = MODE_IDLE;
                end
            end
            MODE_LIT: begin
                if (i_ch == CH_QUOTE && !r_parity) begin
                    mk_n     = 2'd1;
                    kind_a   = KIND_CONTENT_END;
                    n_mode   = MODE_QUAL;
                    n_parity = 1'b0;
                end else begin
                    n_parity = (i_ch == CH_BSLASH) ? ~r_parity : 1'b0;
                end
            end
            MODE_QUAL: begin
                if (i_ch == CH_SPACE) begin
                    mk_n   = 2'd1;
                    mk_pos = prev;
                    kind_a = KIND_QUAL_END;
                    n_mode = MODE_IDLE;
                end
            end
            default: begin
                n_mode = MODE_IDLE;
            end
        endcase

        n_count = sat_add(r_count, mk_n);
        n_ovf   = ovf;
        n_pos   = sat ? r_pos : r_pos + POS_W'(1);

        rec_a   = '{too_long: ovf, idx: r_count, kind: kind_a, pos: to_out_pos(mk_pos)};
        rec_b   = '{too_long: ovf, idx: sat_add(r_count, 2'd1), kind: kind_b,
                    pos: to_out_pos(mk_pos)};
        rec_end = '{too_long: ovf, idx: n_count, kind: KIND_LINE_END, pos: to_out_pos(cur)};

        o_bundle.cnt     = mk_n + {1'b0, i_line_last};
        o_bundle.recs[0] = (mk_n != 2'd0) ? rec_a : rec_end;
        o_bundle.recs[1] = (mk_n == 2'd2) ? rec_b : rec_end;
        o_bundle.recs[2] = rec_end;

        // The line-end marker returns the whole scan state to its idle value.
        if (i_line_last) begin
            n_mode   = MODE_IDLE;
            n_angle  = 1'b0;
            n_parity = 1'b0;
            n_pos    = '0;
            n_count  = '0;
            n_ovf    = 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_mode   <= MODE_IDLE;
            r_angle  <= 1'b0;
            r_parity <= 1'b0;
            r_pos    <= '0;
            r_count  <= '0;
            r_ovf    <= 1'b0;
        end else if (i_accept) begin
            r_mode   <= n_mode;
            r_angle  <= n_angle;
            r_parity <= n_parity;
            r_pos    <= n_pos;
            r_count  <= n_count;
            r_ovf    <= n_ovf;
        end
    end

endmodule

/* rtl/core/ntb_queue.sv */
// ============================================================================
// ntb_queue: short bundle queue between classifier and result sequencer
// A circular buffer of result bundles; the head is visible without a pop.
// ============================================================================
module ntb_queue
    import ntb_pkg::*;
(
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_push,
    input  t_bundle     i_data,
    input  logic        i_pop,
    output t_bundle     o_head,
    output t_q_status   o_status
);

    t_bundle            r_mem [Q_DEPTH];
    logic [Q_PTR_W-1:0] r_wr, r_rd;
    logic [Q_PTR_W:0]   r_cnt, n_cnt;

    always_comb begin
        n_cnt = r_cnt;
        if (i_push && !i_pop) begin
            n_cnt = r_cnt + (Q_PTR_W+1)'(1);
        end else if (i_pop && !i_push) begin
            n_cnt = r_cnt - (Q_PTR_W+1)'(1);
        end
        o_head          = r_mem[r_rd];
        o_status.empty  = (r_cnt == '0);
        o_status.full   = (r_cnt == (Q_PTR_W+1)'(Q_DEPTH));
    end

    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wr] <= i_data;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr  <= '0;
            r_rd  <= '0;
            r_cnt <= '0;
        end else begin
            if (i_push) begin
                r_wr <= r_wr + Q_PTR_W'(1);
            end
            if (i_pop) begin
                r_rd <= r_rd + Q_PTR_W'(1);
            end
            r_cnt <= n_cnt;
        end
    end

endmodule

/* rtl/core/ntb_back.sv */
// ============================================================================
// ntb_back: result sequencer
// Walks the records of the head bundle one per cycle, while i_ready does not
// stall it, into the output register and marks the last record of each bundle.
// ============================================================================
module ntb_back
    import ntb_pkg::*;
(
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  t_bundle     i_head,
    input  t_q_status   i_q_status,
    output logic        o_pop,
    output logic [1:0]  o_sub,
    input  logic        i_ready,
    output logic        o_valid,
    output t_rec        o_rec,
    output logic        o_last
);

    logic       r_valid;
    t_rec       r_rec;
    logic       r_last;
    logic [1:0] r_sub;
    logic       load;
    logic       sel_last;
    t_rec       sel_rec;

    always_comb begin
        load     = !i_q_status.empty && (!r_valid || i_ready);
        sel_last = ((r_sub + 2'd1) == i_head.cnt);
        case (r_sub)
            2'd0:    sel_rec = i_head.recs[0];
            2'd1:    sel_rec = i_head.recs[1];
            default: sel_rec = i_head.recs[2];
        endcase
        o_pop = load && sel_last;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
            r_sub   <= 2'd0;
        end else if (load) begin
            r_valid <= 1'b1;
            r_sub   <= sel_last ? 2'd0 : r_sub + 2'd1;
        end else if (i_ready) begin
            r_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (load) begin
            r_rec  <= sel_rec;
            r_last <= sel_last;
        end
    end

    assign o_valid = r_valid;
    assign o_rec   = r_rec;
    assign o_last  = r_last;
    assign o_sub   = r_sub;

endmodule

/* rtl/core/ntriples_term_boundary_scanner_unit.sv */
// ============================================================================
// ntriples_term_boundary_scanner_unit: N-Triples term boundary scanner
// Reports term starts, content ends, qualifier ends and line ends for a
// stream of N-Triples bytes.
// ============================================================================
// The block takes one byte of an N-Triples line per request on the slave
// side, with tlast on the final byte of the line, and reports boundaries on
// the master side. A term opens at '<', '"' or '_' while no term is open and
// produces a start, a content end and a qualifier end; a '>' closes an IRI
// only when a space follows it, and a literal's closing quote honors
// backslash escapes and may be followed by an @lang or ^^type qualifier that
// runs to the next space. After the last byte of a line a line-end result
// carries the marker count, and all scan state returns to idle. A byte
// produces zero to three results; the master tlast marks the last result of
// each such group. Input bytes are accepted one per cycle whenever the
// four-entry bundle queue has room, and a byte's results pass through the
// bundle queue and then the result sequencer's single output register. The
// output side delivers one result per cycle while results are queued and
// m_axis_tready does not stall it; that single output register sets the
// output rate. Positions beyond LINE_MAX-1 saturate and raise the too-long
// flag for the rest of the line.
// ============================================================================
module ntriples_term_boundary_scanner_unit
    import ntb_pkg::*;
(
    input  logic        i_clk,
    input  logic        i_rst_n,
    // Byte stream in.
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    input  logic [7:0]  s_axis_tdata,   // [7:0] ch
    input  logic        s_axis_tlast,   // line_last
    // Boundary results out.
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    output logic [23:0] m_axis_tdata,   // [11:0] position, [17:12] marker_index,
                                        // [23:18] zero
    output logic [2:0]  m_axis_tuser,   // [1:0] kind, [2] too_long
    output logic        m_axis_tlast    // run_last
);

    t_bundle    front_bundle;
    t_bundle    q_head;
    t_q_status  q_status;
    logic       s_accept;
    logic       q_push;
    logic       q_pop;
    logic [1:0] back_sub;
    t_rec       out_rec;

    // Input flow depends only on queue room, never on the output side.
    assign s_axis_tready = !q_status.full;
    assign s_accept      = s_axis_tvalid && s_axis_tready;
    // Bytes that produce no result leave nothing in the queue.
    assign q_push        = s_accept && (front_bundle.cnt != 2'd0);

    ntb_front u_front (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_accept    (s_accept),
        .i_ch        (s_axis_tdata),
        .i_line_last (s_axis_tlast),
        .o_bundle    (front_bundle)
    );

    ntb_queue u_queue (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_push   (q_push),
        .i_data   (front_bundle),
        .i_pop    (q_pop),
        .o_head   (q_head),
        .o_status (q_status)
    );

    ntb_back u_back (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_head     (q_head),
        .i_q_status (q_status),
        .o_pop      (q_pop),
        .o_sub      (back_sub),
        .i_ready    (m_axis_tready),
        .o_valid    (m_axis_tvalid),
        .o_rec      (out_rec),
        .o_last     (m_axis_tlast)
    );

    assign m_axis_tdata = {6'd0, out_rec.idx, out_rec.pos};
    assign m_axis_tuser = {out_rec.too_long, out_rec.kind};

    // The queue can never look both empty and full.
    a_q_consistent: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !(q_status.empty && q_status.full))
        else $error("bundle queue reports empty and full together");

    // Partway through a bundle, that bundle must still sit at the queue head.
    a_sub_has_head: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (back_sub != 2'd0) |-> (!q_status.empty && back_sub < q_head.cnt))
        else $error("result sequencer index runs past its bundle");

    // A line-end result always closes the group of its byte.
    a_line_end_last: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (m_axis_tvalid && m_axis_tuser[1:0] == KIND_LINE_END) |-> m_axis_tlast)
        else $error("line-end result not marked as last of its group");

    // A bundle pops only when its final record moves into the output register.
    a_pop_then_last: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        q_pop |=> (m_axis_tvalid && m_axis_tlast))
        else $error("bundle popped without its last record reaching the output");

endmodule
